@@ rtl/leb_pkg.sv @@
// ---------------------------------------------------------------------------
// leb_pkg
// Shared types and constants of the line edit buffer.
// ---------------------------------------------------------------------------
package leb_pkg;

  localparam int STORE_DEPTH    = 256;
  localparam int MAX_READ_BURST = 64;
  localparam int AW             = $clog2(STORE_DEPTH);
  localparam int PW             = AW + 1;
  localparam int NW             = $clog2(MAX_READ_BURST + 1);

  typedef enum logic [2:0] {
    MODE_PUT    = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_SEEK   = 3'd2,
    MODE_COMMIT = 3'd3,
    MODE_READ   = 3'd4,
    MODE_POLL   = 3'd5,
    MODE_PEEK   = 3'd6,
    MODE_NOP    = 3'd7
  } mode_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [1:0] WHENCE_START  = 2'd0;
  localparam logic [1:0] WHENCE_CURSOR = 2'd1;
  localparam logic [1:0] WHENCE_END    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MV_RD,
    ST_MV_WR,
    ST_PUT_WR,
    ST_PEEK_RD,
    ST_BURST_RD,
    ST_BURST_CAP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
  } mem_req_t;

endpackage

@@ rtl/leb_ram.sv @@
// ---------------------------------------------------------------------------
// leb_ram
// Text store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module leb_ram (
  input  logic             clk,
  input  leb_pkg::mem_req_t req,
  output logic [7:0]       rdata
);
  import leb_pkg::*;

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    // Read data holds until the next read so a waiting word stays valid.
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/leb_ctrl.sv @@
// ---------------------------------------------------------------------------
// leb_ctrl
// Operation sequencer: pointer registers, byte move engine, result register.
// ---------------------------------------------------------------------------
module leb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        mode,
  input  logic [7:0]        char_in,
  input  logic signed [9:0] offset,
  input  logic [8:0]        count,
  input  logic [1:0]        whence,
  input  logic              before_cursor,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        data_byte,
  output logic [8:0]        cursor_pos,
  output logic [8:0]        line_length,
  output logic [8:0]        readable_length,
  output logic              changed_flag,
  output logic [1:0]        status,
  output logic              last,
  output leb_pkg::mem_req_t mem_req,
  input  logic [7:0]        mem_rdata
);
  import leb_pkg::*;

  state_t        state, state_next;
  mode_t         op;
  logic [PW-1:0] line_start, cursor, line_end;
  logic          dirty;
  logic [PW-1:0] mv_src, mv_dst, mv_len;
  logic          mv_up;
  logic [7:0]    put_char;
  logic [NW-1:0] burst_n, burst_idx;
  logic [1:0]    emit_status;
  logic          peek_hit;

  logic          accept, slot_free, out_load;
  logic [7:0]    load_data;
  logic [1:0]    load_status;
  logic          load_last;

  logic signed [11:0] ls12, cur12, le12, off12, cnt12;
  logic signed [11:0] del_start, del_cnt, del_s, del_e, del_rem, del_cur;
  logic signed [11:0] seek_base;
  logic [PW-1:0]      rd_n;
  logic [PW-1:0]      peek_addr;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    ls12  = {3'b000, line_start};
    cur12 = {3'b000, cursor};
    le12  = {3'b000, line_end};
    off12 = {{2{offset[9]}}, offset};
    cnt12 = {3'b000, count};

    // Delete range, clipped to the line.
    del_start = before_cursor ? (cur12 - ls12 - 12'sd1) : off12;
    del_cnt   = cnt12;
    if (del_start < 0) begin
      del_cnt   = cnt12 + del_start;
      del_start = '0;
    end
    del_s = ls12 + del_start;
    if (del_s > le12) del_s = le12;
    del_e = del_s + del_cnt;
    if (del_e > le12) del_e = le12;
    del_rem = del_e - del_s;
    del_cur = cur12;
    if (cur12 > del_s) begin
      del_cur = cur12 - del_rem;
      if (del_cur < del_s) del_cur = del_s;
    end

    seek_base = cur12;
    if (whence == WHENCE_START) seek_base = ls12;
    else if (whence == WHENCE_END) seek_base = le12;
    if (whence != 2'd3) seek_base = seek_base + off12;
    if (seek_base < ls12) seek_base = ls12;
    if (seek_base > le12) seek_base = le12;

    rd_n = count;
    if (rd_n > PW'(MAX_READ_BURST)) rd_n = PW'(MAX_READ_BURST);
    if (rd_n > line_start) rd_n = line_start;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    out_load    = 1'b0;
    load_data   = 8'd0;
    load_status = emit_status;
    load_last   = 1'b1;
    mem_req     = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          priority case (mode_t'(mode))
            MODE_PUT:    state_next = (line_end >= PW'(STORE_DEPTH)) ? ST_EMIT : ST_MV_RD;
            MODE_DELETE: state_next = (del_cnt > 0) ? ST_MV_RD : ST_EMIT;
            MODE_READ:   state_next = (rd_n != '0) ? ST_BURST_RD : ST_EMIT;
            MODE_PEEK:   state_next = ST_PEEK_RD;
            default:     state_next = ST_EMIT;
          endcase
        end
      end
      ST_MV_RD: begin
        if (mv_len == '0) begin
          priority if (op == MODE_PUT) state_next = ST_PUT_WR;
          else if (op == MODE_READ)    state_next = ST_IDLE;
          else                         state_next = ST_EMIT;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mv_src[AW-1:0];
          state_next      = ST_MV_WR;
        end
      end
      ST_MV_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = mv_dst[AW-1:0];
        mem_req.wr_data = mem_rdata;
        state_next      = ST_MV_RD;
      end
      ST_PUT_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = cursor[AW-1:0];
        mem_req.wr_data = put_char;
        state_next      = ST_EMIT;
      end
      ST_PEEK_RD: begin
        mem_req.rd_en   = peek_hit;
        mem_req.rd_addr = peek_addr[AW-1:0];
        state_next      = ST_EMIT;
      end
      ST_BURST_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = AW'(burst_idx);
        state_next      = ST_BURST_CAP;
      end
      ST_BURST_CAP: begin
        load_data   = mem_rdata;
        load_status = STATUS_OK;
        load_last   = (burst_idx == burst_n - NW'(1));
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = load_last ? ST_MV_RD : ST_BURST_RD;
        end
      end
      ST_EMIT: begin
        load_data = (op == MODE_PEEK && peek_hit) ? mem_rdata : 8'd0;
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_start <= '0;
      cursor     <= '0;
      line_end   <= '0;
      dirty      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op          <= mode_t'(mode);
            put_char    <= char_in;
            emit_status <= STATUS_OK;
            peek_hit    <= (off12 >= 0) && (off12 < (le12 - ls12));
            // The peek address is taken now; the input word is gone afterwards.
            peek_addr   <= line_start + offset[PW-1:0];
            priority case (mode_t'(mode))
              MODE_PUT: begin
                if (line_end >= PW'(STORE_DEPTH)) emit_status <= STATUS_FULL;
                mv_up  <= 1'b1;
                mv_src <= line_end - PW'(1);
                mv_dst <= line_end;
                mv_len <= line_end - cursor;
              end
              MODE_DELETE: begin
                mv_up  <= 1'b0;
                mv_src <= del_e[PW-1:0];
                mv_dst <= del_s[PW-1:0];
                mv_len <= line_end - del_e[PW-1:0];
                if (del_cnt > 0) begin
                  dirty    <= 1'b1;
                  line_end <= line_end - del_rem[PW-1:0];
                  cursor   <= del_cur[PW-1:0];
                end
              end
              MODE_SEEK: cursor <= seek_base[PW-1:0];
              MODE_COMMIT: begin
                line_start <= line_end;
                cursor     <= line_end;
              end
              MODE_READ: begin
                if (line_start == '0) emit_status <= STATUS_EMPTY;
                burst_n   <= rd_n[NW-1:0];
                burst_idx <= '0;
                mv_up     <= 1'b0;
                mv_src    <= rd_n;
                mv_dst    <= '0;
                mv_len    <= line_end - rd_n;
                // Positions move now; results report the state after the drain.
                line_start <= line_start - rd_n;
                cursor     <= cursor - rd_n;
                line_end   <= line_end - rd_n;
              end
              default: ;
            endcase
          end
        end
        ST_MV_WR: begin
          mv_src <= mv_up ? mv_src - PW'(1) : mv_src + PW'(1);
          mv_dst <= mv_up ? mv_dst - PW'(1) : mv_dst + PW'(1);
          mv_len <= mv_len - PW'(1);
        end
        ST_PUT_WR: begin
          cursor   <= cursor + PW'(1);
          line_end <= line_end + PW'(1);
          dirty    <= 1'b1;
        end
        ST_BURST_CAP: if (out_load) burst_idx <= burst_idx + NW'(1);
        ST_EMIT: if (out_load && op == MODE_POLL) dirty <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      data_byte       <= load_data;
      cursor_pos      <= cursor - line_start;
      line_length     <= line_end - line_start;
      readable_length <= line_start;
      changed_flag    <= dirty;
      status          <= load_status;
      last            <= load_last;
    end
  end

endmodule

@@ rtl/line_edit_buffer_top.sv @@
// ---------------------------------------------------------------------------
// line_edit_buffer_top
// Line editing byte store with cursor, built around one text memory.
// ---------------------------------------------------------------------------
// Seek, commit, poll and full puts go straight to the emit state after
// acceptance; peek first reads the memory. Put and delete move the tail
// through the memory one byte at a time, a read and then a write per byte.
// A read burst gives one result word per byte, then shifts the rest down.
// One word is handled at a time; the result register frees the input side.
// Reset (rst, synchronous) clears the pointers, the changed flag and valid.
module line_edit_buffer_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        mode,
  input  logic [7:0]        char_in,
  input  logic signed [9:0] offset,
  input  logic [8:0]        count,
  input  logic [1:0]        whence,
  input  logic              before_cursor,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        data_byte,
  output logic [8:0]        cursor_pos,
  output logic [8:0]        line_length,
  output logic [8:0]        readable_length,
  output logic              changed_flag,
  output logic [1:0]        status,
  output logic              last
);
  import leb_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  leb_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  leb_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .char_in         (char_in),
    .offset          (offset),
    .count           (count),
    .whence          (whence),
    .before_cursor   (before_cursor),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_byte       (data_byte),
    .cursor_pos      (cursor_pos),
    .line_length     (line_length),
    .readable_length (readable_length),
    .changed_flag    (changed_flag),
    .status          (status),
    .last            (last),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata)
  );

endmodule

@@ rtl/leb_checker.sv @@
// ---------------------------------------------------------------------------
// leb_port_checks
// Port level checks of the line edit buffer, bound to the top level.
// ---------------------------------------------------------------------------
module leb_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] data_byte,
  input logic [8:0] cursor_pos,
  input logic [8:0] line_length,
  input logic [8:0] readable_length,
  input logic [1:0] status,
  input logic       last
);
  import leb_pkg::*;

  // A stalled result word stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(last))
    else $error("stalled result word changed");

  // Refusals and empty reads are always single word results.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_FULL || status == STATUS_EMPTY) |-> last)
    else $error("status word not marked last");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_EMPTY |-> data_byte == 8'd0 && readable_length == 9'd0)
    else $error("empty read reported data");

  a_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_pos <= line_length)
    else $error("cursor beyond line end");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, readable_length} + {1'b0, line_length}) <= 10'(STORE_DEPTH))
    else $error("text exceeds store depth");

endmodule

bind line_edit_buffer_top leb_port_checks u_leb_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .data_byte       (data_byte),
  .cursor_pos      (cursor_pos),
  .line_length     (line_length),
  .readable_length (readable_length),
  .status          (status),
  .last            (last)
);
